@@ rtl/oale_pkg.sv @@
`default_nettype none

package oale_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;

  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] OP_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] OP_LOCATE = 2'd2;
  localparam logic [FUNC_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;    // take the request word
    logic rd;      // issue a read at the walk pointer
    logic put;     // write the new value at its slot
    logic finish;  // result word goes out next cycle
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic stream;   // request needs a walk over the entries
    logic put;      // request is an insert that goes ahead
    logic last;     // walk pointer at its final entry
    logic ins_pend; // walk belongs to an insert, value still to place
  } stat_t;

endpackage

`default_nettype wire

@@ rtl/oale_ram.sv @@
`default_nettype none

module oale_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/oale_ctrl.sv @@
`default_nettype none

module oale_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire oale_pkg::stat_t stat_i,
  output oale_pkg::cmd_t      cmd_o,
  output logic                busy_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_PUT   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (stat_i.stream) begin
            state_d = S_RUN;
          end else if (stat_i.put) begin
            state_d = S_PUT;
          end else begin
            cmd_o.finish = 1'b1;
          end
        end
      end
      S_RUN: begin
        cmd_o.rd = 1'b1;
        if (stat_i.last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last read word is handled by the datapath this cycle
        if (stat_i.ins_pend) begin
          state_d = S_PUT;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_PUT: begin
        cmd_o.put    = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

`ifndef ASSERT_OFF
  a_walk_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i && stat_i.stream) |=> (state_q == S_RUN))
    else $error("walk did not start");

  a_drain_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |=> (state_q == S_PUT || state_q == S_IDLE))
    else $error("drain did not finish");

  a_put_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.put |=> !cmd_o.put)
    else $error("value placed twice");
`endif

endmodule

`default_nettype wire

@@ rtl/oale_dpath.sv @@
`default_nettype none

module oale_dpath #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire oale_pkg::cmd_t                          cmd_i,
  output oale_pkg::stat_t                              stat_o,
  input  wire logic        [oale_pkg::FUNC_W-1:0]      func_i,
  input  wire logic        [oale_pkg::POS_W-1:0]       position_i,
  input  wire logic signed [oale_pkg::DATA_W-1:0]      value_i,
  output logic                                         done_o,
  output logic             [oale_pkg::STATUS_W-1:0]    status_o,
  output logic signed      [oale_pkg::DATA_W-1:0]      removed_value_o,
  output logic             [oale_pkg::POS_W-1:0]       found_position_o,
  output logic             [oale_pkg::POS_W-1:0]       count_o
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > oale_pkg::POS_W) ? CNT_W : oale_pkg::POS_W;

  logic [CNT_W-1:0]              count_q;
  logic [oale_pkg::FUNC_W-1:0]   op_q;
  logic [oale_pkg::DATA_W-1:0]   val_q;
  logic [AW-1:0]                 posm1_q;
  logic [AW-1:0]                 ptr_q;
  logic [AW-1:0]                 end_q;
  logic                          rvalid_q;
  logic [AW-1:0]                 rd_addr_q;
  logic [oale_pkg::STATUS_W-1:0] status_q;
  logic [oale_pkg::DATA_W-1:0]   removed_q;
  logic [oale_pkg::POS_W-1:0]    found_q;
  logic                          hit_q;
  logic                          done_q;

  logic [CMP_W-1:0]   cmp_pos, cmp_cnt, cmp_cap, pos_dec;
  logic [CMP_W:0]     cnt_p1;
  logic [CNT_W-1:0]   cnt_dec, rd_pos;
  logic [AW-1:0]      posm1, last_idx;
  logic               pos_zero, ins_bad, full, del_bad, ins_ok, del_ok;
  logic               is_ins, is_del, is_loc, is_clr;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [oale_pkg::DATA_W-1:0] ram_wdata, ram_rdata;

  assign is_ins = (func_i == oale_pkg::OP_INSERT);
  assign is_del = (func_i == oale_pkg::OP_DELETE);
  assign is_loc = (func_i == oale_pkg::OP_LOCATE);
  assign is_clr = (func_i == oale_pkg::OP_CLEAR);

  assign cmp_pos  = CMP_W'(position_i);
  assign cmp_cnt  = CMP_W'(count_q);
  assign cmp_cap  = CMP_W'(CAPACITY);
  assign cnt_p1   = {1'b0, cmp_cnt} + {{CMP_W{1'b0}}, 1'b1};
  assign pos_zero = (position_i == '0);
  assign ins_bad  = pos_zero || ({1'b0, cmp_pos} > cnt_p1);
  assign full     = (cmp_cnt == cmp_cap);
  assign del_bad  = pos_zero || (cmp_pos > cmp_cnt);
  assign ins_ok   = is_ins && !ins_bad && !full;
  assign del_ok   = is_del && !del_bad;

  assign pos_dec  = cmp_pos - {{(CMP_W-1){1'b0}}, 1'b1};
  assign posm1    = pos_dec[AW-1:0];
  assign cnt_dec  = count_q - {{(CNT_W-1){1'b0}}, 1'b1};
  assign last_idx = cnt_dec[AW-1:0];
  assign rd_pos   = CNT_W'(rd_addr_q) + {{(CNT_W-1){1'b0}}, 1'b1};

  // appending at the tail needs no shift
  assign stat_o.stream   = (ins_ok && (cmp_pos <= cmp_cnt)) || del_ok ||
                           (is_loc && (count_q != '0));
  assign stat_o.put      = ins_ok;
  assign stat_o.last     = (ptr_q == end_q);
  assign stat_o.ins_pend = (op_q == oale_pkg::OP_INSERT);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rvalid_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      rvalid_q <= cmd_i.rd;
      done_q   <= cmd_i.finish;
      if (cmd_i.load) begin
        if (ins_ok) begin
          count_q <= count_q + {{(CNT_W-1){1'b0}}, 1'b1};
        end else if (del_ok) begin
          count_q <= cnt_dec;
        end else if (is_clr) begin
          count_q <= '0;
        end
      end
    end
  end

  // request word and walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= func_i;
      val_q     <= value_i;
      posm1_q   <= posm1;
      ptr_q     <= is_ins ? last_idx : (is_del ? posm1 : '0);
      end_q     <= is_ins ? posm1 : last_idx;
      removed_q <= '0;
      found_q   <= '0;
      hit_q     <= 1'b0;
      if (is_ins && ins_bad) begin
        status_q <= oale_pkg::ST_BAD_POS;
      end else if (is_ins && full) begin
        status_q <= oale_pkg::ST_FULL;
      end else if (is_del && del_bad) begin
        status_q <= oale_pkg::ST_BAD_POS;
      end else begin
        status_q <= oale_pkg::ST_OK;
      end
    end
    if (cmd_i.rd) begin
      rd_addr_q <= ptr_q;
      ptr_q     <= (op_q == oale_pkg::OP_INSERT) ? ptr_q - {{(AW-1){1'b0}}, 1'b1}
                                                 : ptr_q + {{(AW-1){1'b0}}, 1'b1};
    end
    if (rvalid_q) begin
      if (op_q == oale_pkg::OP_DELETE && rd_addr_q == posm1_q) begin
        removed_q <= ram_rdata;
      end
      if (op_q == oale_pkg::OP_LOCATE && !hit_q && ram_rdata == val_q) begin
        hit_q   <= 1'b1;
        found_q <= oale_pkg::POS_W'(rd_pos);
      end
    end
  end

  // insert moves each word up one slot, delete moves it down one slot
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_addr_q - {{(AW-1){1'b0}}, 1'b1};
    ram_wdata = ram_rdata;
    if (cmd_i.put) begin
      ram_we    = 1'b1;
      ram_waddr = posm1_q;
      ram_wdata = val_q;
    end else if (rvalid_q) begin
      if (op_q == oale_pkg::OP_INSERT) begin
        ram_we    = 1'b1;
        ram_waddr = rd_addr_q + {{(AW-1){1'b0}}, 1'b1};
      end else if (op_q == oale_pkg::OP_DELETE && rd_addr_q != posm1_q) begin
        ram_we    = 1'b1;
      end
    end
  end

  oale_ram #(
    .WIDTH (oale_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign removed_value_o  = $signed(removed_q);
  assign found_position_o = found_q;
  assign count_o          = oale_pkg::POS_W'(count_q);

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_port_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.put |-> !rvalid_q)
    else $error("write port clash");

  a_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rvalid_q && op_q == oale_pkg::OP_INSERT) |-> (rd_addr_q != AW'(CAPACITY - 1)))
    else $error("insert shift past last slot");
`endif

endmodule

`default_nettype wire

@@ rtl/ordered_array_list_engine.sv @@
`default_nettype none

// Ordered list of signed 32-bit words, up to CAPACITY entries, held in RAM.
// Request channel: func_i, position_i, value_i are taken at a rising edge with
// start_i high and busy_o low. func: insert, delete, locate, clear.
// Result channel: done_o is high for one cycle with status_o, removed_value_o,
// found_position_o and count_o; the receiver cannot stall it and must take
// the word in that cycle. busy_o is low again in the cycle done_o is high.
// Sequence: the walk over the entries reads one RAM word per cycle through the
// single read port, k entries in all (insert: count-position+1, delete:
// count-position+1, locate: count). Delete and locate finish once the last
// word read is handled; an insert that shifts then writes its value; an
// insert at the tail writes its value with no walk; clear, rejected requests
// and locate on an empty list finish at acceptance, the result word registered.
// One request is in flight at a time; the next can be taken at the edge that
// takes the previous result word.
// Reset: the list is empty at once; no clearing pass, stale RAM words are
// never read.

module ordered_array_list_engine #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic        [oale_pkg::FUNC_W-1:0]  func_i,
  input  wire logic        [oale_pkg::POS_W-1:0]   position_i,
  input  wire logic signed [oale_pkg::DATA_W-1:0]  value_i,
  output logic                                     done_o,
  output logic             [oale_pkg::STATUS_W-1:0] status_o,
  output logic signed      [oale_pkg::DATA_W-1:0]  removed_value_o,
  output logic             [oale_pkg::POS_W-1:0]   found_position_o,
  output logic             [oale_pkg::POS_W-1:0]   count_o
);

  oale_pkg::cmd_t  cmd;
  oale_pkg::stat_t stat;

  oale_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  oale_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .func_i           (func_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .removed_value_o  (removed_value_o),
    .found_position_o (found_position_o),
    .count_o          (count_o)
  );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oale_pkg::*;

  localparam int unsigned LIST_DEPTH = 64;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] removed;
    logic [POS_W-1:0]         found;
    logic [POS_W-1:0]         count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [FUNC_W-1:0] func = OP_LOCATE;
  logic [POS_W-1:0] position = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic busy;
  logic done;
  logic [STATUS_W-1:0] status;
  logic signed [DATA_W-1:0] removed_value;
  logic [POS_W-1:0] found_position;
  logic [POS_W-1:0] count;

  // shadow of the list contents, updated as each word is accepted
  logic signed [DATA_W-1:0] list_mem [LIST_DEPTH];
  int unsigned list_len = 0;

  list_result_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned sender_idle_pct = 0;

  ordered_array_list_engine #(
    .CAPACITY(LIST_DEPTH)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_o          (busy),
    .func_i          (func),
    .position_i      (position),
    .value_i         (value),
    .done_o          (done),
    .status_o        (status),
    .removed_value_o (removed_value),
    .found_position_o(found_position),
    .count_o         (count)
  );

  always #10 clk = ~clk;

  task automatic apply_request(input logic [FUNC_W-1:0] f, input int unsigned p,
                               input logic signed [DATA_W-1:0] v,
                               output list_result_t r);
    int unsigned j;
    r = '0;
    r.status = ST_OK;
    case (f)
      OP_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          r.status = ST_BAD_POS;
        end else if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (j = list_len; j > p - 1; j--) list_mem[j] = list_mem[j-1];
          list_mem[p-1] = v;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > list_len) begin
          r.status = ST_BAD_POS;
        end else begin
          r.removed = list_mem[p-1];
          for (j = p - 1; j + 1 < list_len; j++) list_mem[j] = list_mem[j+1];
          list_len--;
        end
      end
      OP_LOCATE: begin
        for (j = 0; j < list_len; j++) begin
          if (r.found == 0 && list_mem[j] == v) r.found = POS_W'(j + 1);
        end
      end
      default: begin
        list_len = 0;
      end
    endcase
    r.count = POS_W'(list_len);
  endtask

  // one word in: optional idle cycles, then hold start until taken
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                              input logic signed [DATA_W-1:0] v);
    list_result_t want;
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start    <= 1'b1;
    func     <= f;
    position <= p;
    value    <= v;
    do @(posedge clk); while (busy);
    apply_request(f, p, v, want);
    pending_results.push_back(want);
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result word with nothing expected: status %0d removed %h found %0d count %0d",
                   $time, status, removed_value, found_position, count);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status || removed_value !== want.removed ||
            found_position !== want.found || count !== want.count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: expected status %0d removed %h found %0d count %0d, got status %0d removed %h found %0d count %0d",
                     $time, want.status, want.removed, want.found, want.count,
                     status, removed_value, found_position, count);
        end
      end
    end
  end

  task automatic test_empty_list();
    send_request(OP_LOCATE, 7'd0, 32'sd5);
    send_request(OP_DELETE, 7'd1, '0);
    send_request(OP_INSERT, 7'd0, 32'sd1);
    send_request(OP_INSERT, 7'd2, 32'sd1);
    send_request(OP_DELETE, 7'd0, '0);
    send_request(OP_INSERT, 7'd127, '1);
  endtask

  task automatic test_directed_edges();
    send_request(OP_INSERT, 7'd1, 32'sh8000_0000);
    send_request(OP_INSERT, 7'd2, 32'sh7fff_ffff);
    send_request(OP_INSERT, 7'd1, -32'sd1);
    send_request(OP_INSERT, 7'd2, 32'sd0);
    // duplicate at the tail, locate must report the first one
    send_request(OP_INSERT, 7'd5, -32'sd1);
    send_request(OP_LOCATE, 7'd0, -32'sd1);
    send_request(OP_LOCATE, 7'd3, 32'sh7fff_ffff);
    send_request(OP_LOCATE, 7'd0, 32'sd12345);
    send_request(OP_DELETE, 7'd6, '0);
    send_request(OP_DELETE, 7'd127, '0);
    send_request(OP_DELETE, 7'd3, '0);
    send_request(OP_DELETE, 7'd4, '0);
    send_request(OP_DELETE, 7'd1, '0);
    send_request(OP_INSERT, 7'h55, 32'sd9);
    send_request(OP_CLEAR, 7'd0, '0);
    // stale words after clear must not match
    send_request(OP_LOCATE, 7'd0, 32'sd0);
    send_request(OP_DELETE, 7'd1, '0);
  endtask

  task automatic test_fill_to_capacity();
    int unsigned i;
    for (i = 0; i < LIST_DEPTH; i++)
      send_request(OP_INSERT, POS_W'($urandom_range(list_len + 1, 1)), $urandom);
    send_request(OP_INSERT, 7'd65, 32'sd3);
    send_request(OP_INSERT, 7'd66, 32'sd3);
    send_request(OP_INSERT, 7'd1, 32'sd3);
    send_request(OP_LOCATE, 7'd0, list_mem[LIST_DEPTH-1]);
    send_request(OP_DELETE, 7'd64, '0);
    send_request(OP_DELETE, 7'd64, '0);
    send_request(OP_INSERT, 7'd64, $urandom);
    send_request(OP_INSERT, 7'd64, $urandom);
    send_request(OP_CLEAR, 7'd0, '0);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(99) < 40) return $signed(DATA_W'($urandom_range(7))) - 32'sd4;
    return $urandom;
  endfunction

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned n_words);
    int unsigned i;
    int unsigned roll;
    int unsigned fill_goal;
    logic [FUNC_W-1:0] f;
    logic [POS_W-1:0] p;
    logic signed [DATA_W-1:0] v;
    sender_idle_pct = idle_pct;
    fill_goal = 8;
    for (i = 0; i < n_words; i++) begin
      // move the target fill level now and then; mostly short lists
      if ($urandom_range(59) == 0) begin
        roll = $urandom_range(99);
        if (roll < 50)      fill_goal = $urandom_range(12);
        else if (roll < 80) fill_goal = $urandom_range(40, 13);
        else                fill_goal = LIST_DEPTH;
      end
      roll = $urandom_range(99);
      v = pick_value();
      if (roll < 2) begin
        f = OP_CLEAR;
      end else if (roll < 20) begin
        f = OP_LOCATE;
        if (list_len > 0 && $urandom_range(99) < 60)
          v = list_mem[$urandom_range(list_len - 1)];
      end else if (list_len < fill_goal) begin
        f = ($urandom_range(99) < 75) ? OP_INSERT : OP_DELETE;
      end else begin
        f = ($urandom_range(99) < 25) ? OP_INSERT : OP_DELETE;
      end
      if ($urandom_range(99) < 10)
        p = POS_W'($urandom_range(127));
      else if (f == OP_INSERT)
        p = POS_W'($urandom_range(list_len + 1, 1));
      else if (f == OP_DELETE && list_len > 0)
        p = POS_W'($urandom_range(list_len, 1));
      else
        p = POS_W'($urandom_range(127));
      send_request(f, p, v);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    sender_idle_pct = 17;
    test_empty_list();
    test_directed_edges();
    test_fill_to_capacity();
    test_random_traffic(17, 470);
    test_random_traffic(85, 470);
    test_random_traffic(0, 470);
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #15ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
